[rtl/ilist_pkg.sv]
// shared types and codes for the indexed list engine
package ilist_pkg;

    // width of a position on the request word
    localparam int POS_W = 8;
    // width of a stored value
    localparam int DATA_W = 32;

    // request kinds
    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_READ   = 2'd2
    } req_kind_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_READ_RANGE   = 2'd1,
        ST_INSERT_FULL  = 2'd2,
        ST_REMOVE_EMPTY = 2'd3
    } status_t;

    // shift command broadcast to every cell
    typedef struct packed {
        logic             insert;
        logic             remove;
        logic [POS_W-1:0] at;
        logic [POS_W-1:0] last;
    } cell_cmd_t;

endpackage

[rtl/ilist_cell.sv]
// one storage cell of the list chain
module ilist_cell #(
    parameter int IDX = 0
) (
    input  logic                              clk,
    input  ilist_pkg::cell_cmd_t              cmd,
    input  logic signed [ilist_pkg::DATA_W-1:0] new_value,
    input  logic signed [ilist_pkg::DATA_W-1:0] left_value,
    input  logic signed [ilist_pkg::DATA_W-1:0] right_value,
    output logic signed [ilist_pkg::DATA_W-1:0] value
);
    import ilist_pkg::*;

    localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;

    // pick this cell's next entry from the shift command
    always_comb
    begin
        value_next = value_reg;
        if (cmd.insert)
        begin
            if (MY_POS > cmd.at)
                value_next = left_value;
            else if (MY_POS == cmd.at)
                value_next = new_value;
        end
        else if (cmd.remove)
        begin
            if ((MY_POS >= cmd.at) && (MY_POS < cmd.last))
                value_next = right_value;
        end
    end

    // entry storage, contents undefined until written
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

[rtl/indexed_list_engine.sv]
// indexed list engine: ordered list of signed values held in a chain of shifting cells
// a result word is registered and appears on the output register in the cycle after its request is taken
// throughput: one request word per cycle while in_stall is low; every cell shifts in parallel in that cycle
// the next request sees the list left by the previous one without extra cycles
// reset clears the entry count and the output valid; cell contents stay undefined
// a stalled output blocks new requests only while the held result is not taken
module indexed_list_engine #(
    parameter int CAPACITY = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          req_type,
    input  logic [ilist_pkg::POS_W-1:0]         position,
    input  logic signed [ilist_pkg::DATA_W-1:0] new_value,
    input  logic signed [ilist_pkg::DATA_W-1:0] fallback_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [ilist_pkg::DATA_W-1:0] read_data,
    output logic [$clog2(CAPACITY+1)-1:0]       entry_count,
    output logic [1:0]                          status
);
    import ilist_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic signed [DATA_W-1:0] read_data_reg;
    logic signed [DATA_W-1:0] read_data_next;
    status_t                  status_reg;
    status_t                  status_next;

    logic                     accept;
    logic                     full;
    logic                     empty;
    logic [POS_W-1:0]         count_pos;
    logic [POS_W-1:0]         last_pos;
    logic [POS_W-1:0]         ins_at;
    logic [POS_W-1:0]         rem_at;
    logic                     in_range;
    logic signed [DATA_W-1:0] sel_value;
    cell_cmd_t                cmd;

    logic signed [DATA_W-1:0] cell_value [CAPACITY];
    logic signed [DATA_W-1:0] cell_left  [CAPACITY];
    logic signed [DATA_W-1:0] cell_right [CAPACITY];

    // handshake: take a word unless a finished result is held under out_stall
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    // list bounds
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign count_pos = POS_W'(count_reg);
    assign last_pos  = count_pos - POS_W'(1);
    assign ins_at    = (position < count_pos) ? position : count_pos;
    assign rem_at    = (position < last_pos) ? position : last_pos;
    assign in_range  = (position < count_pos);

    // shift command for the chain
    always_comb
    begin
        cmd.insert = accept && (req_type == REQ_INSERT) && !full;
        cmd.remove = accept && (req_type == REQ_REMOVE) && !empty;
        cmd.at     = (req_type == REQ_INSERT) ? ins_at : rem_at;
        cmd.last   = last_pos;
    end

    // chain of cells, each fed by its neighbors
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        if (g == 0)
        begin : g_first
            assign cell_left[g] = '0;
        end
        else
        begin : g_inner_l
            assign cell_left[g] = cell_value[g-1];
        end
        if (g == CAPACITY - 1)
        begin : g_last
            assign cell_right[g] = '0;
        end
        else
        begin : g_inner_r
            assign cell_right[g] = cell_value[g+1];
        end

        ilist_cell #(
            .IDX (g)
        ) u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .new_value   (new_value),
            .left_value  (cell_left[g]),
            .right_value (cell_right[g]),
            .value       (cell_value[g])
        );
    end

    // read select across the cells
    always_comb
    begin
        sel_value = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (position == POS_W'(i))
                sel_value = cell_value[i];
        end
    end

    // next count and result word
    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        read_data_next = read_data_reg;
        status_next    = status_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (accept)
        begin
            out_valid_next = 1'b1;
            read_data_next = '0;
            status_next    = ST_OK;
            case (req_type)
                REQ_INSERT:
                begin
                    if (full)
                        status_next = ST_INSERT_FULL;
                    else
                        count_next = count_reg + CNT_W'(1);
                end
                REQ_REMOVE:
                begin
                    if (empty)
                        status_next = ST_REMOVE_EMPTY;
                    else
                        count_next = count_reg - CNT_W'(1);
                end
                REQ_READ:
                begin
                    if (in_range)
                        read_data_next = sel_value;
                    else
                    begin
                        read_data_next = fallback_value;
                        status_next    = ST_READ_RANGE;
                    end
                end
                default:
                begin
                    read_data_next = '0;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload registers
    always_ff @(posedge clk)
    begin
        read_data_reg <= read_data_next;
        status_reg    <= status_next;
    end

    assign out_valid   = out_valid_reg;
    assign read_data   = read_data_reg;
    assign entry_count = count_reg;
    assign status      = status_reg;

    // count never passes capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // a taken insert into a list with room grows it by one
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req_type == REQ_INSERT) && !full)
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not grow the list");

    // a remove on an empty list reports it and leaves the count at zero
    a_remove_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req_type == REQ_REMOVE) && empty)
        |=> (out_valid_reg && (status_reg == ST_REMOVE_EMPTY) && (count_reg == '0)))
        else $error("remove on empty not reported");

    // a full-drop result is only shown with a full list
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == ST_INSERT_FULL)) |-> full)
        else $error("full status with room in list");

endmodule
